### rtl/assert_macros.svh
// Assertion macros used by the checker file of the pair scorer.
// Depends on nothing; the includer supplies clock, reset and expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SNPS_ASSERT_IMP(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |-> (post)) \
    else $error("pair scorer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SNPS_ASSERT_NXT(label, clk, rstn, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (pre) |=> (post)) \
    else $error("pair scorer assertion failed");

`endif

### rtl/snps_pkg.sv
// Types and constants of the shared neighbor pair scorer.
// Used by the engine, the top level and the checker; depends on nothing.
`default_nettype none
package snps_pkg;

  localparam int MAX_POINTS_DEF    = 1024;
  localparam int MAX_NEIGHBORS_DEF = 32;

  localparam logic [5:0]  K_RESET = 6'd32;
  localparam logic [32:0] NO_SUM  = 33'h1_FFFF_FFFF;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [9:0]  point_a;
    logic [9:0]  point_b;
    logic [4:0]  slot;
    logic [9:0]  neighbor_id;
    logic [31:0] neighbor_dist;
  } in_t;

  typedef struct packed {
    logic [5:0]  shared_cnt;
    logic [32:0] min_dist_sum;
    logic        shares_any;
  } out_t;

  typedef struct packed {
    logic [9:0]  id;
    logic [31:0] distance;
  } entry_t;

endpackage
`default_nettype wire

### rtl/snps_fifo.sv
// Two-entry first-in first-out queue with push/full and pop/empty sides.
// Generic in width; depends on nothing.
`default_nettype none
module snps_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] data_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop) rptr_q <= ~rptr_q;
      if (do_push && !do_pop) count_q <= count_q + 2'd1;
      else if (do_pop && !do_push) count_q <= count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) data_q[wptr_q] <= wdata_i;
  end

endmodule
`default_nettype wire

### rtl/snps_engine.sv
// Back end of the pair scorer: neighbor table memory, loads and pair queries.
// Depends on snps_pkg.
`default_nettype none
module snps_engine #(
  parameter int MaxPoints    = snps_pkg::MAX_POINTS_DEF,
  parameter int MaxNeighbors = snps_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [5:0]      k_cfg_i,
  input  logic            cmd_valid_i,
  input  snps_pkg::in_t   cmd_i,
  output logic            cmd_pop_o,
  input  logic            res_full_i,
  output logic            res_push_o,
  output snps_pkg::out_t  res_o
);

  localparam int PW    = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int SW    = (MaxNeighbors > 1) ? $clog2(MaxNeighbors) : 1;
  localparam int KW    = $clog2(MaxNeighbors + 1);
  localparam int AW    = PW + SW;
  localparam int Depth = 1 << AW;

  typedef enum logic [1:0] {ST_IDLE, ST_READ_B, ST_READ_A, ST_DRAIN} state_e;

  state_e               state_q;
  logic [KW-1:0]        k_q, cnt_q, k_act;
  logic [PW-1:0]        pa_q, pb_q;
  logic                 rd_v_q, rd_isa_q;
  logic [SW-1:0]        rd_idx_q;
  snps_pkg::entry_t     rdata_q;
  snps_pkg::entry_t     mem_q [Depth];
  logic [9:0]           bid_q [MaxNeighbors];
  logic [31:0]          bdist_q [MaxNeighbors];
  logic [MaxNeighbors-1:0] matched_q, eq, unm;
  logic                 s1_v_q;
  logic [31:0]          s1_da_q, s1_db_q;
  logic [5:0]           common_q;
  logic [32:0]          best_q, sum;
  logic [SW-1:0]        first_idx, unm_idx;
  logic                 any_eq, any_unm;

  logic [16:0]          pa_ext, pb_ext;
  logic                 pa_ok, pb_ok, slot_ok, is_query, do_write, re;
  logic [AW-1:0]        raddr, waddr;
  logic [6:0]           k_lim;
  logic                 last_cnt;

  assign pa_ext   = {7'd0, cmd_i.point_a};
  assign pb_ext   = {7'd0, cmd_i.point_b};
  assign pa_ok    = (pa_ext < 17'(MaxPoints));
  assign pb_ok    = (pb_ext < 17'(MaxPoints));
  assign slot_ok  = ({2'd0, cmd_i.slot} < 7'(MaxNeighbors));
  assign is_query = (cmd_i.cmd == snps_pkg::CMD_QUERY);

  // Zero acts as one, anything above the list size acts as the list size.
  always_comb begin
    k_lim = {1'b0, k_cfg_i};
    if (k_lim == 7'd0) k_lim = 7'd1;
    if (k_lim > 7'(MaxNeighbors)) k_lim = 7'(MaxNeighbors);
    k_act = KW'(k_lim);
  end

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i && (!is_query || !res_full_i);
  assign do_write  = cmd_pop_o && !is_query && pa_ok && slot_ok;
  assign waddr     = {pa_ext[PW-1:0], cmd_i.slot[SW-1:0]};
  assign re        = (state_q == ST_READ_B) || (state_q == ST_READ_A);
  assign raddr     = (state_q == ST_READ_B) ? {pb_q, cnt_q[SW-1:0]} : {pa_q, cnt_q[SW-1:0]};
  assign last_cnt  = (cnt_q == k_q - KW'(1));

  always_ff @(posedge clk_i) begin
    if (do_write) mem_q[waddr] <= '{id: cmd_i.neighbor_id, distance: cmd_i.neighbor_dist};
    if (re) rdata_q <= mem_q[raddr];
  end

  // Match of one list A entry against the held list B.
  always_comb begin
    first_idx = '0;
    unm_idx   = '0;
    for (int j = 0; j < MaxNeighbors; j++) begin
      eq[j] = (KW'(j) < k_q) && (bid_q[j] == rdata_q.id);
    end
    unm     = eq & ~matched_q;
    any_eq  = |eq;
    any_unm = |unm;
    for (int j = MaxNeighbors - 1; j >= 0; j--) begin
      if (eq[j]) first_idx = SW'(j);
      if (unm[j]) unm_idx = SW'(j);
    end
  end

  assign sum = {1'b0, s1_da_q} + {1'b0, s1_db_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      k_q       <= '0;
      cnt_q     <= '0;
      pa_q      <= '0;
      pb_q      <= '0;
      rd_v_q    <= 1'b0;
      rd_isa_q  <= 1'b0;
      rd_idx_q  <= '0;
      matched_q <= '0;
      s1_v_q    <= 1'b0;
      common_q  <= '0;
      best_q    <= snps_pkg::NO_SUM;
    end else begin
      rd_v_q   <= re;
      rd_isa_q <= (state_q == ST_READ_A);
      rd_idx_q <= cnt_q[SW-1:0];
      s1_v_q   <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (cmd_pop_o && is_query) begin
            k_q       <= k_act;
            pa_q      <= pa_ext[PW-1:0];
            pb_q      <= pb_ext[PW-1:0];
            cnt_q     <= '0;
            matched_q <= '0;
            common_q  <= '0;
            best_q    <= snps_pkg::NO_SUM;
            state_q   <= (pa_ok && pb_ok) ? ST_READ_B : ST_DRAIN;
          end
        end
        ST_READ_B: begin
          cnt_q <= last_cnt ? '0 : cnt_q + KW'(1);
          if (last_cnt) state_q <= ST_READ_A;
        end
        ST_READ_A: begin
          cnt_q <= cnt_q + KW'(1);
          if (last_cnt) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (res_push_o) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
      if (rd_v_q && rd_isa_q) begin
        // Greedy pairing with the lowest unpaired equal entry gives the
        // multiset intersection. The first list A occurrence of an id is the
        // one that finds the first equal list B entry still unpaired.
        if (any_unm) begin
          matched_q[unm_idx] <= 1'b1;
          common_q           <= common_q + 6'd1;
        end
        if (any_eq && !matched_q[first_idx]) s1_v_q <= 1'b1;
      end
      if (s1_v_q && (sum < best_q)) best_q <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_v_q && !rd_isa_q) begin
      bid_q[rd_idx_q]   <= rdata_q.id;
      bdist_q[rd_idx_q] <= rdata_q.distance;
    end
    s1_da_q <= rdata_q.distance;
    s1_db_q <= bdist_q[first_idx];
  end

  assign res_push_o         = (state_q == ST_DRAIN) && !rd_v_q && !s1_v_q;
  assign res_o.shared_cnt   = common_q;
  assign res_o.min_dist_sum = best_q;
  assign res_o.shares_any   = (common_q != 6'd0);

endmodule
`default_nettype wire

### rtl/shared_neighbor_pair_scorer.sv
// Top level of the shared neighbor pair scorer: queues, engine, k register.
// Depends on snps_pkg, snps_fifo and snps_engine.
`default_nettype none
// The block keeps a k-nearest-neighbor table of MaxPoints lists with
// MaxNeighbors entries each and answers pair queries on it. A load transaction
// (cmd 0) writes one neighbor id and distance and produces no result; a query
// transaction (cmd 1) produces one result with the shared id count, the least
// summed distance over a shared neighbor and a shared flag. Transactions enter
// a two-entry command queue and results leave through a two-entry result
// queue, so either side may stall without holding the other. In a query, where
// k is the active neighbor count, the single read port of the table memory
// first fetches the k entries of the second point into registers, then
// streams the k entries of the first point past a parallel compare against
// them. Write the neighbor count register only while no transaction is in
// flight.
module shared_neighbor_pair_scorer #(
  parameter int MaxPoints    = snps_pkg::MAX_POINTS_DEF,
  parameter int MaxNeighbors = snps_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [5:0]     cfg_data_i,
  input  logic           push,
  output logic           full,
  input  snps_pkg::in_t  in_i,
  output logic           empty,
  input  logic           pop,
  output snps_pkg::out_t out_o
);

  logic [5:0]     kreg_q;
  logic           cmd_empty, cmd_pop;
  logic           res_full, res_push;
  logic [$bits(snps_pkg::in_t)-1:0]  cmd_data;
  logic [$bits(snps_pkg::out_t)-1:0] res_data;
  snps_pkg::out_t res_in;

  // The configuration channel never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kreg_q <= snps_pkg::K_RESET;
    end else begin
      if (cfg_valid_i && cfg_ready_o) kreg_q <= cfg_data_i;
    end
  end

  snps_fifo #(.Width($bits(snps_pkg::in_t))) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .wdata_i (in_i),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .rdata_o (cmd_data)
  );

  snps_engine #(
    .MaxPoints    (MaxPoints),
    .MaxNeighbors (MaxNeighbors)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .k_cfg_i     (kreg_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (snps_pkg::in_t'(cmd_data)),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  snps_fifo #(.Width($bits(snps_pkg::out_t))) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_data)
  );

  assign out_o = snps_pkg::out_t'(res_data);

endmodule
`default_nettype wire

### rtl/snps_checker.sv
// Port-level checks of the shared neighbor pair scorer, bound to the top level.
// Depends on snps_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module snps_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           empty,
  input wire logic           pop,
  input wire snps_pkg::out_t out_o
);

  logic shown, no_sum, cnt_nz;

  assign shown  = !empty;
  assign no_sum = (out_o.min_dist_sum == snps_pkg::NO_SUM);
  assign cnt_nz = (out_o.shared_cnt != 6'd0);

  // The flag agrees with the count of the shown result.
  `SNPS_ASSERT_IMP(a_flag_count, clk_i, rst_ni, shown, out_o.shares_any == cnt_nz)
  // With nothing shared the sum is the all-ones marker.
  `SNPS_ASSERT_IMP(a_none_sum, clk_i, rst_ni, shown && !out_o.shares_any, no_sum)
  // A real shared neighbor never reaches the all-ones marker.
  `SNPS_ASSERT_IMP(a_some_sum, clk_i, rst_ni, shown && out_o.shares_any, !no_sum)
  // A shown result that is not taken stays unchanged.
  `SNPS_ASSERT_NXT(a_hold, clk_i, rst_ni, shown && !pop, shown && $stable(out_o))

endmodule

bind shared_neighbor_pair_scorer snps_checker u_snps_checker (.*);
`default_nettype wire

### tb/tb_top.sv
// Self-checking testbench of the shared neighbor pair scorer.
// Depends on snps_pkg and shared_neighbor_pair_scorer; loads kNN lists, runs pair
// queries and checks each result against a built-in neighbor table predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPTS = 1024;
  localparam int NNB = 32;
  localparam int IDLE_LIMIT = 20000;
  localparam int TAIL_CYCLES = 100;
  // A long receiver hold-off, well past the time to fill both queues.
  localparam int HOLD_CYCLES = 600;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [5:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  snps_pkg::in_t in_i = '0;
  logic empty;
  logic pop = 1'b0;
  snps_pkg::out_t out_o;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  shared_neighbor_pair_scorer u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i),
    .push(push), .full(full), .in_i(in_i),
    .empty(empty), .pop(pop), .out_o(out_o)
  );

  // Predictor state: a private copy of the kNN table and of k.
  logic [9:0] nbr_id_tbl [NPTS*NNB];
  logic [31:0] nbr_dist_tbl [NPTS*NNB];
  logic [5:0] k_reg = snps_pkg::K_RESET;
  snps_pkg::out_t pending_scores [$];

  int mismatches = 0;
  int queries_sent = 0;
  int loads_sent = 0;
  int scores_checked = 0;
  int shared_hits = 0;
  int idle_cycles = 0;
  bit hold_off = 1'b0;
  bit hold_req = 1'b0;

  // Scores one pair as the block should: multiset intersection of the first k
  // ids, with the least sum of first-occurrence distances over shared ids.
  function automatic snps_pkg::out_t score_pair(input logic [9:0] pa, input logic [9:0] pb);
    snps_pkg::out_t r;
    int k;
    int ca;
    int cb;
    int fa;
    int fb;
    int common;
    logic [32:0] best;
    logic [32:0] s;
    common = 0;
    best = snps_pkg::NO_SUM;
    k = (k_reg == 0) ? 1 : ((k_reg > NNB) ? NNB : int'(k_reg));
    for (int i = 0; i < k; i++) begin
      ca = 0; cb = 0; fa = -1; fb = -1;
      for (int j = 0; j < k; j++) begin
        if (nbr_id_tbl[pa*NNB+j] == nbr_id_tbl[pa*NNB+i]) begin
          if (fa < 0) fa = j;
          ca++;
        end
        if (nbr_id_tbl[pb*NNB+j] == nbr_id_tbl[pa*NNB+i]) begin
          if (fb < 0) fb = j;
          cb++;
        end
      end
      if (fa == i && cb != 0) begin
        common += (ca < cb) ? ca : cb;
        s = {1'b0, nbr_dist_tbl[pa*NNB+fa]} + {1'b0, nbr_dist_tbl[pb*NNB+fb]};
        if (s < best) best = s;
      end
    end
    r.shared_cnt = common[5:0];
    r.min_dist_sum = best;
    r.shares_any = (common != 0);
    return r;
  endfunction

  // Sends one transaction in a burst: push stays high back to back while the
  // caller keeps sending, and drops only between bursts.
  task automatic send_item(input snps_pkg::in_t item);
    push <= 1'b1;
    in_i <= item;
    do @(posedge clk_i); while (full);
    if (item.cmd == snps_pkg::CMD_LOAD) begin
      nbr_id_tbl[item.point_a*NNB+item.slot] = item.neighbor_id;
      nbr_dist_tbl[item.point_a*NNB+item.slot] = item.neighbor_dist;
      loads_sent++;
    end else begin
      pending_scores.insert(pending_scores.size(), score_pair(item.point_a, item.point_b));
      queries_sent++;
    end
  endtask

  // A gap of zero keeps the burst going, so the next call must send an item
  // or drop push itself.
  task automatic end_burst(input int gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_load(input logic [9:0] pa, input logic [4:0] sl,
                           input logic [9:0] id, input logic [31:0] d);
    snps_pkg::in_t it;
    it = '0;
    it.cmd = snps_pkg::CMD_LOAD;
    it.point_a = pa;
    it.slot = sl;
    it.neighbor_id = id;
    it.neighbor_dist = d;
    it.point_b = 10'($urandom);
    send_item(it);
  endtask

  task automatic send_query(input logic [9:0] pa, input logic [9:0] pb);
    snps_pkg::in_t it;
    it = '0;
    it.cmd = snps_pkg::CMD_QUERY;
    it.point_a = pa;
    it.point_b = pb;
    // Fields a query ignores carry noise.
    it.slot = 5'($urandom);
    it.neighbor_id = 10'($urandom);
    it.neighbor_dist = $urandom;
    send_item(it);
  endtask

  // Fills a whole list, ids drawn from a small pool so that lists overlap.
  task automatic load_list(input logic [9:0] pa, input int pool);
    for (int s = 0; s < NNB; s++)
      send_load(pa, 5'(s), 10'($urandom_range(pool - 1, 0)), $urandom);
  endtask

  // Waits until every expected result has come, then lets the engine settle
  // before the neighbor count may change, since a load leaves no result.
  task automatic drain();
    push <= 1'b0;
    while (pending_scores.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_k(input logic [5:0] k);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= k;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    k_reg = k;
  endtask

  // Directed part: extreme fields, duplicate ids, disjoint lists, both
  // points the same, and the largest distances so the sum needs bit 32.
  task automatic test_directed();
    load_list(10'd0, 4);
    load_list(10'd1023, 4);
    for (int s = 0; s < NNB; s++)
      send_load(10'd512, 5'(s), 10'd1023 - 10'(s), 32'hFFFF_FFFF);
    send_load(10'd1023, 5'd31, 10'd1023, 32'hFFFF_FFFF);
    send_load(10'd1023, 5'd0, 10'd992, 32'hFFFF_FFFF);
    end_burst(3);
    send_query(10'd0, 10'd1023);
    send_query(10'd1023, 10'd512);
    send_query(10'd0, 10'd512);
    send_query(10'd512, 10'd512);
    send_query(10'd0, 10'd0);
    end_burst(1);
  endtask

  task automatic test_k_settings();
    logic [5:0] ks [6];
    ks = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd33, 6'd7};
    foreach (ks[i]) begin
      set_k(ks[i]);
      send_query(10'd0, 10'd1023);
      send_query(10'd512, 10'd1023);
      send_query(10'd0, 10'd0);
      end_burst(0);
    end
  endtask

  // Random part: mostly fully loaded points queried in pairs, some single
  // overwrites with random content, bursts with random gaps between them.
  task automatic test_random(input int n_items);
    int pts [$];
    int sent;
    int burst;
    int new_pt;
    sent = 0;
    pts = {0, 512, 1023};
    while (sent < n_items) begin
      burst = $urandom_range(12, 1);
      for (int b = 0; b < burst; b++) begin
        case ($urandom_range(9, 0))
          0: begin
            new_pt = int'($urandom_range(NPTS - 1, 0));
            load_list(10'(new_pt), 24);
            pts.insert(pts.size(), new_pt);
            sent += NNB;
          end
          1, 2: begin
            send_load(10'(pts[$urandom_range(pts.size() - 1, 0)]), 5'($urandom),
                      10'($urandom_range(23, 0)), $urandom);
            sent++;
          end
          default: begin
            send_query(10'(pts[$urandom_range(pts.size() - 1, 0)]),
                       10'(pts[$urandom_range(pts.size() - 1, 0)]));
            sent++;
          end
        endcase
      end
      end_burst(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1));
    end
  endtask

  // The receiver stops for a long stretch while queries keep coming, so both
  // queues fill and full must rise; afterwards the sender waits for all results.
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 12; i++) send_query(10'd0, 10'd1023);
    end_burst(0);
    drain();
  endtask

  // Receiver: stalls on a repeating pattern mixed with random stalls, plus a
  // long counted hold-off when the backpressure test asks for one.
  always @(posedge clk_i) begin
    static int phase = 0;
    static int hold_cnt = 0;
    phase <= (phase + 1) % 37;
    if (hold_req && !hold_off) begin
      hold_off <= 1'b1;
      hold_cnt = 0;
      hold_req <= 1'b0;
      pop <= 1'b0;
    end else if (hold_off) begin
      hold_cnt++;
      if (hold_cnt >= HOLD_CYCLES) hold_off <= 1'b0;
      pop <= 1'b0;
    end else if (phase < 12) begin
      pop <= 1'b1;
    end else begin
      pop <= ($urandom_range(2, 0) != 0);
    end
  end

  // Result checker, sampling at the edge where a result is accepted.
  always @(posedge clk_i) begin
    snps_pkg::out_t exp_r;
    if (rst_ni && pop && !empty) begin
      if (pending_scores.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %p", out_o);
      end else begin
        exp_r = pending_scores.pop_front();
        scores_checked++;
        if (exp_r.shares_any) shared_hits++;
        if (out_o.shared_cnt !== exp_r.shared_cnt ||
            out_o.min_dist_sum !== exp_r.min_dist_sum ||
            out_o.shares_any !== exp_r.shares_any) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result %0d expected count %0d sum %h any %0b, got %0d %h %0b",
                     scores_checked, exp_r.shared_cnt, exp_r.min_dist_sum,
                     exp_r.shares_any, out_o.shared_cnt, out_o.min_dist_sum,
                     out_o.shares_any);
        end
      end
    end
  end

  // Watchdog: cycles with no accepted transaction on either side and no receiver hold-off.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || hold_off) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_k_settings();
    set_k(6'd32);
    test_random(260);
    test_backpressure();
    set_k(6'd5);
    test_random(80);
    set_k(6'd32);
    test_random(80);
    drain();
    if (pending_scores.size() != 0) mismatches++;
    $display("Covered %0d loads and %0d queries, %0d results checked, %0d with a shared id.",
             loads_sent, queries_sent, scores_checked, shared_hits);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches in total", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl
rtl/snps_pkg.sv
rtl/snps_fifo.sv
rtl/snps_engine.sv
rtl/shared_neighbor_pair_scorer.sv
rtl/snps_checker.sv
tb/tb_top.sv
